// ===== rtl/fpbd_pkg.sv =====
package fpbd_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int HDR_MIN_BYTES = 20;
	localparam logic [3:0] HDR_MIN_WORDS = 4'(HDR_MIN_BYTES / 4);
	localparam logic [3:0] IDLE_MAX = 4'hf;
	localparam logic [3:0] IDLE_LIMIT_RESET = 4'd10;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_SYMBOL = 1'b1;

	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_NEW_FLOW = 3'd1;
	localparam logic [2:0] ST_BAD_IP = 3'd2;
	localparam logic [2:0] ST_BAD_TCP = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	localparam logic [1:0] SYM_ZERO = 2'd0;
	localparam logic [1:0] SYM_ONE = 2'd1;
	localparam logic [1:0] SYM_IDLE = 2'd2;

	typedef enum logic {
		CFG_IDLE_LIMIT = 1'b0,
		CFG_START_PHASE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_UPD,
		S_WALK
	} back_state_t;

	typedef struct packed {
		logic opcode;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] frame_length;
		logic [2:0] hdr_status;
	} q_item_t;

endpackage

// ===== rtl/fpbd_front.sv =====
module fpbd_front import fpbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [31:0] src_address,
	input logic [31:0] dst_address,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [3:0] ip_header_words,
	input logic [3:0] tcp_header_words,
	input logic [15:0] frame_length,
	output logic q_valid,
	output q_item_t q_item,
	input logic q_pop
);

	q_item_t q_mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] count_q;
	q_item_t new_item;
	logic push;
	logic pop;

	always_comb begin
		new_item.opcode = opcode;
		new_item.src_address = src_address;
		new_item.dst_address = dst_address;
		new_item.src_port = src_port;
		new_item.dst_port = dst_port;
		new_item.frame_length = frame_length;
		if (ip_header_words < HDR_MIN_WORDS) begin
			new_item.hdr_status = ST_BAD_IP;
		end else if (tcp_header_words < HDR_MIN_WORDS) begin
			new_item.hdr_status = ST_BAD_TCP;
		end else begin
			new_item.hdr_status = ST_COUNTED;
		end
	end

	assign in_stall = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/fpbd_back.sv =====
module fpbd_back import fpbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic cfg_index,
	input logic [3:0] cfg_data,
	input logic q_valid,
	input q_item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [2:0] status,
	output logic [31:0] flow_src_address,
	output logic [31:0] flow_dst_address,
	output logic [15:0] flow_src_port,
	output logic [15:0] flow_dst_port,
	output logic [1:0] symbol,
	output logic last
);

	localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TABLE_ENTRIES - 1);

	back_state_t state_q, state_d;
	q_item_t cur_q;
	logic [3:0] idle_limit_q;
	logic second_half_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] key_sa_q [TABLE_ENTRIES];
	logic [31:0] key_da_q [TABLE_ENTRIES];
	logic [15:0] key_sp_q [TABLE_ENTRIES];
	logic [15:0] key_dp_q [TABLE_ENTRIES];
	logic [31:0] bf_q [TABLE_ENTRIES];
	logic [31:0] bs_q [TABLE_ENTRIES];
	logic [3:0] idle_q [TABLE_ENTRIES];
	logic hit_q;
	logic [TBL_AW-1:0] hit_idx_q;
	logic free_any_q;
	logic [TBL_AW-1:0] free_idx_q;
	logic [TBL_AW-1:0] walk_idx_q;

	logic out_valid_q;
	logic kind_q;
	logic [2:0] status_q;
	logic [31:0] osa_q;
	logic [31:0] oda_q;
	logic [15:0] osp_q;
	logic [15:0] odp_q;
	logic [1:0] sym_q;
	logic last_q;

	logic [TABLE_ENTRIES-1:0] match;
	logic [TABLE_ENTRIES-1:0] emit_mask;
	logic [TABLE_ENTRIES-1:0] above_mask;
	logic match_any;
	logic [TBL_AW-1:0] match_idx;
	logic free_any;
	logic [TBL_AW-1:0] free_idx;
	logic out_free;
	logic lookup_en;
	logic pkt_en;
	logic walk_en;
	logic tick_toggle;
	logic cur_emit;
	logic later_emit;
	logic hdr_ok;
	logic [2:0] pkt_status;
	logic [TBL_AW-1:0] upd_idx;
	logic [31:0] flen_ext;
	logic [1:0] walk_sym;

	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = valid_q[i] && key_sa_q[i] == cur_q.src_address
				&& key_da_q[i] == cur_q.dst_address && key_sp_q[i] == cur_q.src_port
				&& key_dp_q[i] == cur_q.dst_port;
			emit_mask[i] = valid_q[i] && (idle_q[i] < idle_limit_q);
			above_mask[i] = (TBL_AW'(i) > walk_idx_q);
		end
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_any = 1'b1;
				match_idx = TBL_AW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = TBL_AW'(i);
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign cur_emit = emit_mask[walk_idx_q];
	assign later_emit = |(emit_mask & above_mask);
	assign hdr_ok = (cur_q.hdr_status == ST_COUNTED);
	assign upd_idx = hit_q ? hit_idx_q : free_idx_q;
	assign flen_ext = {16'd0, cur_q.frame_length};

	always_comb begin
		if (!hdr_ok) begin
			pkt_status = cur_q.hdr_status;
		end else if (hit_q) begin
			pkt_status = ST_COUNTED;
		end else if (free_any_q) begin
			pkt_status = ST_NEW_FLOW;
		end else begin
			pkt_status = ST_TABLE_FULL;
		end
		if (idle_q[walk_idx_q] != '0) begin
			walk_sym = SYM_IDLE;
		end else if (bf_q[walk_idx_q] < bs_q[walk_idx_q]) begin
			walk_sym = SYM_ONE;
		end else begin
			walk_sym = SYM_ZERO;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		lookup_en = 1'b0;
		pkt_en = 1'b0;
		walk_en = 1'b0;
		tick_toggle = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cur_q.opcode == OP_PACKET) begin
					lookup_en = 1'b1;
					state_d = S_UPD;
				end else if (second_half_q) begin
					state_d = S_WALK;
				end else begin
					tick_toggle = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_UPD: begin
				if (out_free) begin
					pkt_en = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				walk_en = !cur_emit || out_free;
				if (walk_en && walk_idx_q == LAST_IDX) begin
					tick_toggle = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idle_limit_q <= IDLE_LIMIT_RESET;
			second_half_q <= 1'b0;
			valid_q <= '0;
			walk_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_IDLE_LIMIT: idle_limit_q <= cfg_data;
					CFG_START_PHASE: second_half_q <= cfg_data[0];
					default: ;
				endcase
			end else if (tick_toggle) begin
				second_half_q <= !second_half_q;
			end
			if (pkt_en && hdr_ok && (hit_q || free_any_q)) begin
				valid_q[upd_idx] <= 1'b1;
			end
			if (walk_en) begin
				walk_idx_q <= (walk_idx_q == LAST_IDX) ? '0 : walk_idx_q + 1'b1;
				if (valid_q[walk_idx_q] && !cur_emit) begin
					valid_q[walk_idx_q] <= 1'b0;
				end
			end
			if (pkt_en || (walk_en && cur_emit)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (lookup_en) begin
			hit_q <= match_any;
			hit_idx_q <= match_idx;
			free_any_q <= free_any;
			free_idx_q <= free_idx;
		end
		if (pkt_en && hdr_ok && (hit_q || free_any_q)) begin
			idle_q[upd_idx] <= '0;
			if (hit_q) begin
				if (second_half_q) begin
					bs_q[upd_idx] <= bs_q[upd_idx] + flen_ext;
				end else begin
					bf_q[upd_idx] <= bf_q[upd_idx] + flen_ext;
				end
			end else begin
				key_sa_q[upd_idx] <= cur_q.src_address;
				key_da_q[upd_idx] <= cur_q.dst_address;
				key_sp_q[upd_idx] <= cur_q.src_port;
				key_dp_q[upd_idx] <= cur_q.dst_port;
				bf_q[upd_idx] <= second_half_q ? '0 : flen_ext;
				bs_q[upd_idx] <= second_half_q ? flen_ext : '0;
			end
		end
		if (walk_en && cur_emit) begin
			bf_q[walk_idx_q] <= '0;
			bs_q[walk_idx_q] <= '0;
			if (idle_q[walk_idx_q] != IDLE_MAX) begin
				idle_q[walk_idx_q] <= idle_q[walk_idx_q] + 1'b1;
			end
		end
		if (pkt_en) begin
			kind_q <= KIND_STATUS;
			status_q <= pkt_status;
			osa_q <= cur_q.src_address;
			oda_q <= cur_q.dst_address;
			osp_q <= cur_q.src_port;
			odp_q <= cur_q.dst_port;
			sym_q <= SYM_ZERO;
			last_q <= 1'b1;
		end else if (walk_en && cur_emit) begin
			kind_q <= KIND_SYMBOL;
			status_q <= ST_COUNTED;
			osa_q <= key_sa_q[walk_idx_q];
			oda_q <= key_da_q[walk_idx_q];
			osp_q <= key_sp_q[walk_idx_q];
			odp_q <= key_dp_q[walk_idx_q];
			sym_q <= walk_sym;
			last_q <= !later_emit;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign status = status_q;
	assign flow_src_address = osa_q;
	assign flow_dst_address = oda_q;
	assign flow_src_port = osp_q;
	assign flow_dst_port = odp_q;
	assign symbol = sym_q;
	assign last = last_q;

	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cur_q.opcode == OP_PACKET) |-> $onehot0(match))
		else $error("flow key held in more than one slot");

	a_alloc_one: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= $past($countones(valid_q)) + 1)
		else $error("more than one slot allocated in a cycle");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_STATUS) |-> last_q)
		else $error("packet status word without last");

	a_walk_symbols: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && walk_en && cur_emit) |=> (out_valid_q && kind_q == KIND_SYMBOL))
		else $error("walk emitted a word of the wrong kind");

endmodule

// ===== rtl/flow_pulse_bit_decoder_top.sv =====
// A packet word goes from the head of the queue to its status word in steps: it is taken
// from the queue, its key is matched over all table slots in parallel, then the counters
// are updated and the output register loaded, which waits while the output is stalled.
// A tick word that closes a full period walks every slot in turn, one slot a cycle unless
// an emitting slot meets a stalled output; a tick closing the first half flips the phase.
// A two-word queue between header check and table takes input while the table is busy.
module flow_pulse_bit_decoder_top import fpbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic cfg_index,
	input logic [3:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [31:0] src_address,
	input logic [31:0] dst_address,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [3:0] ip_header_words,
	input logic [3:0] tcp_header_words,
	input logic [15:0] frame_length,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [2:0] status,
	output logic [31:0] flow_src_address,
	output logic [31:0] flow_dst_address,
	output logic [15:0] flow_src_port,
	output logic [15:0] flow_dst_port,
	output logic [1:0] symbol,
	output logic last
);

	logic q_valid;
	logic q_pop;
	q_item_t q_item;

	fpbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.src_address(src_address),
		.dst_address(dst_address),
		.src_port(src_port),
		.dst_port(dst_port),
		.ip_header_words(ip_header_words),
		.tcp_header_words(tcp_header_words),
		.frame_length(frame_length),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	fpbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.status(status),
		.flow_src_address(flow_src_address),
		.flow_dst_address(flow_dst_address),
		.flow_src_port(flow_src_port),
		.flow_dst_port(flow_dst_port),
		.symbol(symbol),
		.last(last)
	);

endmodule

// ===== tb/flow_pulse_bit_decoder_checker.sv =====
module flow_pulse_bit_decoder_checker import fpbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic cfg_index,
	input logic [3:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic opcode,
	input logic [31:0] src_address,
	input logic [31:0] dst_address,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [3:0] ip_header_words,
	input logic [3:0] tcp_header_words,
	input logic [15:0] frame_length,
	input logic out_valid,
	input logic out_stall,
	input logic result_kind,
	input logic [2:0] status,
	input logic [31:0] flow_src_address,
	input logic [31:0] flow_dst_address,
	input logic [15:0] flow_src_port,
	input logic [15:0] flow_dst_port,
	input logic [1:0] symbol,
	input logic last,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic kind;
		logic [2:0] st;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [1:0] sym;
		logic lst;
	} word_t;

	word_t expected_words[$];
	logic [3:0] lim;
	logic phase;
	logic used [TABLE_ENTRIES];
	logic [31:0] ksa [TABLE_ENTRIES];
	logic [31:0] kda [TABLE_ENTRIES];
	logic [15:0] ksp [TABLE_ENTRIES];
	logic [15:0] kdp [TABLE_ENTRIES];
	logic [31:0] first_bytes [TABLE_ENTRIES];
	logic [31:0] second_bytes [TABLE_ENTRIES];
	logic [3:0] idle_cnt [TABLE_ENTRIES];

	assign pending = expected_words.size();

	task automatic predict_packet();
		word_t w;
		int hit;
		int fr;
		hit = -1;
		fr = -1;
		w = '0;
		w.kind = KIND_STATUS;
		w.sa = src_address;
		w.da = dst_address;
		w.sp = src_port;
		w.dp = dst_port;
		w.sym = SYM_ZERO;
		w.lst = 1'b1;
		if (ip_header_words < HDR_MIN_WORDS) begin
			w.st = ST_BAD_IP;
		end else if (tcp_header_words < HDR_MIN_WORDS) begin
			w.st = ST_BAD_TCP;
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (used[i]) begin
					if (hit < 0 && ksa[i] == src_address && kda[i] == dst_address &&
							ksp[i] == src_port && kdp[i] == dst_port)
						hit = i;
				end else if (fr < 0) begin
					fr = i;
				end
			end
			w.st = ST_COUNTED;
			if (hit < 0) begin
				if (fr < 0) begin
					w.st = ST_TABLE_FULL;
				end else begin
					hit = fr;
					used[hit] = 1'b1;
					ksa[hit] = src_address;
					kda[hit] = dst_address;
					ksp[hit] = src_port;
					kdp[hit] = dst_port;
					first_bytes[hit] = '0;
					second_bytes[hit] = '0;
					w.st = ST_NEW_FLOW;
				end
			end
			if (hit >= 0) begin
				if (phase)
					second_bytes[hit] = second_bytes[hit] + 32'(frame_length);
				else
					first_bytes[hit] = first_bytes[hit] + 32'(frame_length);
				idle_cnt[hit] = '0;
			end
		end
		expected_words.push_back(w);
	endtask

	task automatic predict_tick();
		word_t w;
		int n;
		n = 0;
		if (phase) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!used[i]) continue;
				if (idle_cnt[i] >= lim) begin
					used[i] = 1'b0;
					continue;
				end
				w = '0;
				w.kind = KIND_SYMBOL;
				w.st = ST_COUNTED;
				w.sa = ksa[i];
				w.da = kda[i];
				w.sp = ksp[i];
				w.dp = kdp[i];
				if (idle_cnt[i] == 0)
					w.sym = (first_bytes[i] < second_bytes[i]) ? SYM_ONE : SYM_ZERO;
				else
					w.sym = SYM_IDLE;
				expected_words.push_back(w);
				n++;
				first_bytes[i] = '0;
				second_bytes[i] = '0;
				if (idle_cnt[i] != IDLE_MAX) idle_cnt[i] = idle_cnt[i] + 4'd1;
			end
			if (n > 0) expected_words[$].lst = 1'b1;
		end
		phase = !phase;
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t got;
		word_t exp_w;
		if (!arst_n) begin
			fail_count <= 0;
			expected_words.delete();
			lim = IDLE_LIMIT_RESET;
			phase = 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				used[i] = 1'b0;
				idle_cnt[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				got = {result_kind, status, flow_src_address, flow_dst_address,
					flow_src_port, flow_dst_port, symbol, last};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (got !== exp_w) begin
						$display("%0t: mismatch, expected %h, actual %h", $time, exp_w, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_write) begin
				if (cfg_index == CFG_IDLE_LIMIT)
					lim = cfg_data;
				else
					phase = cfg_data[0];
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_PACKET)
					predict_packet();
				else
					predict_tick();
			end
		end
	end
endmodule

// ===== tb/flow_pulse_bit_decoder_top_tb.sv =====
module flow_pulse_bit_decoder_top_tb import fpbd_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_index;
	logic [3:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [31:0] src_address;
	logic [31:0] dst_address;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [3:0] ip_header_words;
	logic [3:0] tcp_header_words;
	logic [15:0] frame_length;
	logic out_valid;
	logic out_stall;
	logic result_kind;
	logic [2:0] status;
	logic [31:0] flow_src_address;
	logic [31:0] flow_dst_address;
	logic [15:0] flow_src_port;
	logic [15:0] flow_dst_port;
	logic [1:0] symbol;
	logic last;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_recv;
	longint cycle_count;

	flow_pulse_bit_decoder_top dut (.*);
	flow_pulse_bit_decoder_checker chk (.*);

	logic [31:0] pool_sa [8];
	logic [31:0] pool_da [8];
	logic [15:0] pool_sp [8];
	logic [15:0] pool_dp [8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_word(input logic op, input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp, input logic [3:0] ipw,
			input logic [3:0] tcpw, input logic [15:0] flen);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		src_address <= sa;
		dst_address <= da;
		src_port <= sp;
		dst_port <= dp;
		ip_header_words <= ipw;
		tcp_header_words <= tcpw;
		frame_length <= flen;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_packet(input int f, input logic [15:0] flen);
		send_word(OP_PACKET, pool_sa[f], pool_da[f], pool_sp[f], pool_dp[f], 4'd5, 4'd5, flen);
	endtask

	task automatic send_tick();
		send_word(OP_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
			4'($urandom), 16'($urandom));
	endtask

	task automatic drain_and_write(input cfg_reg_t idx, input logic [3:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_word();
		int r;
		int f;
		r = $urandom_range(99);
		f = $urandom_range(7);
		if (r < 20)
			send_tick();
		else if (r < 75)
			send_packet(f, 16'($urandom));
		else if (r < 85)
			send_word(OP_PACKET, $urandom, $urandom, 16'($urandom), 16'($urandom),
				4'($urandom_range(15, 5)), 4'($urandom_range(15, 5)), 16'($urandom));
		else
			send_word(OP_PACKET, $urandom, $urandom, 16'($urandom), 16'($urandom),
				4'($urandom), 4'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_IDLE_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_PACKET;
		src_address = '0;
		dst_address = '0;
		src_port = '0;
		dst_port = '0;
		ip_header_words = '0;
		tcp_header_words = '0;
		frame_length = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b0;
		for (int i = 0; i < 8; i++) begin
			pool_sa[i] = $urandom;
			pool_da[i] = $urandom;
			pool_sp[i] = 16'($urandom);
			pool_dp[i] = 16'($urandom);
		end
		pool_sa[0] = '1; pool_da[0] = '1; pool_sp[0] = '1; pool_dp[0] = '1;
		pool_sa[1] = '0; pool_da[1] = '0; pool_sp[1] = '0; pool_dp[1] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_PACKET, '1, '1, '1, '1, 4'd4, 4'd4, 16'hffff);
		send_word(OP_PACKET, '0, '0, '0, '0, 4'd5, 4'd4, 16'h0);
		send_word(OP_PACKET, '1, '0, '1, '0, 4'd15, 4'd15, 16'hffff);
		send_packet(0, 16'hffff);
		send_packet(1, 16'd0);
		send_packet(0, 16'd1);
		send_tick();
		send_packet(1, 16'd5);
		send_packet(0, 16'hffff);
		send_tick();
		send_tick();
		send_tick();
		for (int i = 0; i < 33; i++)
			send_word(OP_PACKET, i, ~i, 16'(i), 16'(~i), 4'd5, 4'd5, 16'hffff);
		send_tick();
		send_tick();

		drain_and_write(CFG_IDLE_LIMIT, 4'd0);
		drain_and_write(CFG_START_PHASE, 4'd1);
		send_packet(2, 16'd9);
		send_tick();
		send_tick();
		send_tick();

		drain_and_write(CFG_IDLE_LIMIT, 4'd15);
		drain_and_write(CFG_START_PHASE, 4'd0);
		for (int i = 0; i < 45; i++) random_word();

		send_idle_pct = 65;
		drain_and_write(CFG_IDLE_LIMIT, 4'd1);
		for (int i = 0; i < 40; i++) random_word();

		send_idle_pct = 0;
		recv_stall_pct = 65;
		drain_and_write(CFG_IDLE_LIMIT, 4'd3);
		drain_and_write(CFG_START_PHASE, 4'd1);
		for (int i = 0; i < 40; i++) random_word();

		send_idle_pct = 20;
		recv_stall_pct = 20;
		drain_and_write(CFG_IDLE_LIMIT, 4'd10);
		fork
			begin
				hold_recv = 1'b1;
				repeat (300) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 55; i++) random_word();
		join
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== flow_pulse_bit_decoder_top.f =====
rtl/fpbd_pkg.sv
rtl/fpbd_front.sv
rtl/fpbd_back.sv
rtl/flow_pulse_bit_decoder_top.sv
tb/flow_pulse_bit_decoder_checker.sv
tb/flow_pulse_bit_decoder_top_tb.sv
